FILE: rtl/core/multi_keyword_occurrence_counter_defines.svh
// assertion macros for the keyword occurrence counter
`ifndef MULTI_KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH
`define MULTI_KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MKOC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MKOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mkoc_pkg.sv
// shared types and constants for the keyword occurrence counter
`timescale 1ns / 1ps

package mkoc_pkg;

	localparam int BYTE_W      = 8;
	localparam int KEY_W       = 64;
	localparam int LEN_FIELD_W = 3;
	localparam int NUM_OUT     = 4;
	localparam int OUT_COUNT_W = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int LENS_W      = NUM_OUT * LEN_FIELD_W;
	localparam int IN_USE_W    = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_A       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_B       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_C       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_D       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_LENGTHS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORDS_IN_USE = 3'd5;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

endpackage

FILE: rtl/core/mkoc_window.sv
// history window of recent bytes with saturating fill count
`timescale 1ns / 1ps

module mkoc_window
	import mkoc_pkg::*;
#(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  win_ctrl_t                 ctrl,
	input  logic [BYTE_W-1:0]         cur_byte,
	output logic [((MAX_KEYWORD_LEN > 1) ? MAX_KEYWORD_LEN - 1 : 1)-1:0][BYTE_W-1:0] window,
	output logic [$clog2(((MAX_KEYWORD_LEN > 1) ? MAX_KEYWORD_LEN - 1 : 1) + 1)-1:0] seen
);

	localparam int WIN_DEPTH = (MAX_KEYWORD_LEN > 1) ? MAX_KEYWORD_LEN - 1 : 1;
	localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);
	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WIN_DEPTH);

	logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_q;
	logic [SEEN_W-1:0]                seen_q;

	// bytes beyond the fill count cannot produce a hit, so no clear is needed
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			win_q[0] <= cur_byte;
			for (int j = 1; j < WIN_DEPTH; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (ctrl.clear) begin
			seen_q <= '0;
		end else if (ctrl.shift && seen_q != SEEN_MAX) begin
			seen_q <= seen_q + SEEN_W'(1);
		end
	end

	assign window = win_q;
	assign seen   = seen_q;

endmodule

FILE: rtl/core/mkoc_match.sv
// compare of one keyword against the current byte and the history window
`timescale 1ns / 1ps

module mkoc_match
	import mkoc_pkg::*;
#(
	parameter int MAX_KEYWORD_LEN = 8
) (
	input  logic [BYTE_W-1:0]         cur_byte,
	input  logic [((MAX_KEYWORD_LEN > 1) ? MAX_KEYWORD_LEN - 1 : 1)-1:0][BYTE_W-1:0] window,
	input  logic [$clog2(((MAX_KEYWORD_LEN > 1) ? MAX_KEYWORD_LEN - 1 : 1) + 1)-1:0] seen,
	input  logic [KEY_W-1:0]          keyword,
	input  logic [LEN_FIELD_W-1:0]    len_field,
	output logic                      hit
);

	localparam int WIN_DEPTH = (MAX_KEYWORD_LEN > 1) ? MAX_KEYWORD_LEN - 1 : 1;
	localparam logic [LEN_FIELD_W-1:0] LEN_CAP = LEN_FIELD_W'(MAX_KEYWORD_LEN - 1);

	logic [MAX_KEYWORD_LEN-1:0][BYTE_W-1:0] text;
	logic [LEN_FIELD_W-1:0]                 len_m1;

	// text[0] is the byte now arriving, text[j] the j-th earlier byte
	always_comb begin
		text[0] = cur_byte;
		for (int j = 1; j < MAX_KEYWORD_LEN; j++) begin
			text[j] = window[j-1];
		end
	end

	assign len_m1 = (len_field > LEN_CAP) ? LEN_CAP : len_field;

	always_comb begin
		logic [LEN_FIELD_W-1:0] kpos;
		hit  = (4'(len_m1) <= 4'(seen));
		kpos = '0;
		for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
			if (LEN_FIELD_W'(i) <= len_m1) begin
				kpos = len_m1 - LEN_FIELD_W'(i);
				if (keyword[{kpos, 3'b000} +: BYTE_W] != text[i]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/core/multi_keyword_occurrence_counter.sv
// top level: stream handshake, configuration, per-keyword saturating counters
`timescale 1ns / 1ps
`include "multi_keyword_occurrence_counter_defines.svh"

// Counts overlapping occurrences of up to four keywords (1 to 8 bytes each) in a
// byte stream. One byte is taken per cycle, except while a last byte is held back; a
// byte is held in an input register, then compared against every enabled keyword and
// counted into the counters as it leaves that register, and a last byte's counts are
// registered in the output register as it leaves. Only a byte with tlast set produces
// a transaction: the four counts including that byte, after which counters and
// history restart. While a result waits for m_axis_tready, non-last bytes keep flowing;
// a further last byte waits in the input register until the output register is free.
// Configuration is written through cfg_we/cfg_index/cfg_data while the stream is idle.
module multi_keyword_occurrence_counter
	import mkoc_pkg::*;
#(
	parameter int MAX_KEYWORDS    = 4,
	parameter int MAX_KEYWORD_LEN = 8,
	parameter int COUNT_WIDTH     = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0]           cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [BYTE_W-1:0]               s_axis_tdata,  // data_byte
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [NUM_OUT*OUT_COUNT_W-1:0]  m_axis_tdata   // count_a, count_b, count_c, count_d
);

	localparam int WIN_DEPTH = (MAX_KEYWORD_LEN > 1) ? MAX_KEYWORD_LEN - 1 : 1;
	localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);

	logic [MAX_KEYWORDS-1:0][KEY_W-1:0]       keyword_q;
	logic [LENS_W-1:0]                        lengths_q;
	logic [IN_USE_W-1:0]                      in_use_q;

	logic                                     valid_s1;
	logic [BYTE_W-1:0]                        byte_s1;
	logic                                     last_s1;

	logic                                     out_valid_q;
	logic [NUM_OUT-1:0][OUT_COUNT_W-1:0]      out_data_q;
	logic [NUM_OUT-1:0][OUT_COUNT_W-1:0]      out_next;

	logic [MAX_KEYWORDS-1:0][COUNT_WIDTH-1:0] cnt_q;
	logic [MAX_KEYWORDS-1:0][COUNT_WIDTH-1:0] cnt_next;
	logic [MAX_KEYWORDS-1:0]                  hit;

	logic [WIN_DEPTH-1:0][BYTE_W-1:0]         window;
	logic [SEEN_W-1:0]                        seen;
	win_ctrl_t                                win_ctrl;

	logic                                     out_free;
	logic                                     consume;
	logic                                     accept;

	// configuration registers
	for (genvar gk = 0; gk < MAX_KEYWORDS; gk++) begin : g_key
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				keyword_q[gk] <= '0;
			end else if (cfg_we && cfg_index == CFG_KEYWORD_A + CFG_IDX_W'(gk)) begin
				keyword_q[gk] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lengths_q <= '0;
			in_use_q  <= IN_USE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEYWORD_LENGTHS: lengths_q <= cfg_data[LENS_W-1:0];
				CFG_KEYWORDS_IN_USE: in_use_q  <= cfg_data[IN_USE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign out_free      = !out_valid_q || m_axis_tready;
	assign consume       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || consume;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// history window
	assign win_ctrl.shift = consume && !last_s1;
	assign win_ctrl.clear = consume && last_s1;

	mkoc_window #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (win_ctrl),
		.cur_byte (byte_s1),
		.window   (window),
		.seen     (seen)
	);

	// keyword compare and counters
	for (genvar gk = 0; gk < MAX_KEYWORDS; gk++) begin : g_cnt
		mkoc_match #(
			.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
		) u_match (
			.cur_byte  (byte_s1),
			.window    (window),
			.seen      (seen),
			.keyword   (keyword_q[gk]),
			.len_field (lengths_q[gk*LEN_FIELD_W +: LEN_FIELD_W]),
			.hit       (hit[gk])
		);

		assign cnt_next[gk] = (in_use_q > IN_USE_W'(gk) && hit[gk] && cnt_q[gk] != '1) ?
			cnt_q[gk] + COUNT_WIDTH'(1) : cnt_q[gk];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[gk] <= '0;
			end else if (consume) begin
				cnt_q[gk] <= last_s1 ? '0 : cnt_next[gk];
			end
		end
	end

	for (genvar go = 0; go < NUM_OUT; go++) begin : g_out
		if (go < MAX_KEYWORDS) begin : g_used
			assign out_next[go] = OUT_COUNT_W'(cnt_next[go]);
		end else begin : g_unused
			assign out_next[go] = '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			out_data_q <= out_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`MKOC_ASSERT_NEXT(a_last_restarts, consume && last_s1, out_valid_q && seen == '0, "last byte did not restart stream and raise result")
	`MKOC_ASSERT_NOW(a_seen_bound, 1'b1, seen <= SEEN_W'(WIN_DEPTH), "fill count beyond window depth")
	`MKOC_ASSERT_NEXT(a_s1_hold, valid_s1 && !consume, valid_s1 && $stable(byte_s1) && $stable(last_s1), "input register lost a waiting byte")

endmodule
